### rtl/lsmt_pkg.sv
// Package for the scanline and mode timer: timing constants, mode codes,
// state and result structures. No dependencies.

package lsmt_pkg;

  localparam int LINE_CYCLES   = 456;
  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;

  localparam int ACC_W  = 10;
  localparam int LINE_W = 8;
  localparam int CYC_W  = 8;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              match;
  } lsmt_state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              line_match;
    logic              stat_interrupt;
    logic              vblank_interrupt;
    logic              line_drawn;
    logic [LINE_W-1:0] drawn_line;
  } lsmt_result_t;

endpackage

### rtl/lsmt_if.sv
// Valid/ready channel interfaces for the scanline and mode timer.
// Depends on lsmt_pkg for field widths.

interface lsmt_item_if;
  import lsmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CYC_W-1:0]  cycles;
  logic              ppu_enable;
  logic [LINE_W-1:0] compare_line;
  logic              compare_int_select;
  logic              hblank_int_select;
  logic              vblank_int_select;
  logic              oam_int_select;

  modport source (output valid, cycles, ppu_enable, compare_line, compare_int_select,
                  hblank_int_select, vblank_int_select, oam_int_select,
                  input ready);
  modport sink (input valid, cycles, ppu_enable, compare_line, compare_int_select,
                hblank_int_select, vblank_int_select, oam_int_select,
                output ready);
endinterface

interface lsmt_result_if;
  import lsmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [LINE_W-1:0] line;
  logic              line_match;
  logic              stat_interrupt;
  logic              vblank_interrupt;
  logic              line_drawn;
  logic [LINE_W-1:0] drawn_line;

  modport source (output valid, mode, line, line_match, stat_interrupt,
                  vblank_interrupt, line_drawn, drawn_line,
                  input ready);
  modport sink (input valid, mode, line, line_match, stat_interrupt,
                vblank_interrupt, line_drawn, drawn_line,
                output ready);
endinterface

### rtl/lsmt_step.sv
// Next-state logic of the scanline and mode timer for one transfer.
// Depends on lsmt_pkg.

module lsmt_step (
  input  lsmt_pkg::lsmt_state_t      cur,
  input  logic [lsmt_pkg::CYC_W-1:0] cycles,
  input  logic                       ppu_enable,
  input  logic [lsmt_pkg::LINE_W-1:0] compare_line,
  input  logic                       compare_int_select,
  input  logic                       hblank_int_select,
  input  logic                       vblank_int_select,
  input  logic                       oam_int_select,
  output lsmt_pkg::lsmt_state_t      nxt,
  output lsmt_pkg::lsmt_result_t     res
);
  import lsmt_pkg::*;

  logic [ACC_W:0]    sum_wide;
  logic [ACC_W-1:0]  sum_sat;
  logic              line_step;
  logic [LINE_W:0]   line_inc;
  mode_t             mode_work;
  logic [LINE_W-1:0] line_work;
  logic              stat_irq;
  logic              vblank_irq;
  logic              drawn;

  assign sum_wide  = {1'b0, cur.acc} + (ACC_W+1)'(cycles);
  assign sum_sat   = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];
  assign line_step = sum_sat >= ACC_W'(LINE_CYCLES);
  assign line_inc  = {1'b0, cur.line} + (LINE_W+1)'(1);

  always_comb begin
    mode_work  = cur.mode;
    line_work  = cur.line;
    stat_irq   = 1'b0;
    vblank_irq = 1'b0;
    drawn      = 1'b0;
    nxt        = cur;
    if (ppu_enable && line_step) begin
      if (mode_work == MODE_OAM) begin
        mode_work = MODE_DRAW;
      end
      if (mode_work == MODE_DRAW) begin
        drawn     = 1'b1;
        mode_work = MODE_HBLANK;
        stat_irq  = hblank_int_select;
      end
      line_work = line_inc[LINE_W-1:0];
      if (mode_work == MODE_HBLANK) begin
        if (line_inc >= (LINE_W+1)'(VISIBLE_LINES)) begin
          mode_work  = MODE_VBLANK;
          vblank_irq = vblank_int_select;
        end else begin
          mode_work = MODE_OAM;
        end
      end else if (line_inc > (LINE_W+1)'(LAST_LINE)) begin
        line_work = '0;
        mode_work = MODE_OAM;
        stat_irq  = stat_irq | oam_int_select;
      end
      nxt.match = (line_work == compare_line);
      if (line_work == compare_line) begin
        stat_irq = stat_irq | compare_int_select;
      end
      nxt.acc  = sum_sat - ACC_W'(LINE_CYCLES);
      nxt.mode = mode_work;
      nxt.line = line_work;
    end else if (ppu_enable) begin
      nxt.acc = sum_sat;
    end
  end

  always_comb begin
    res.mode             = ppu_enable ? nxt.mode : MODE_HBLANK;
    res.line             = nxt.line;
    res.line_match       = nxt.match;
    res.stat_interrupt   = stat_irq;
    res.vblank_interrupt = vblank_irq;
    res.line_drawn       = drawn;
    res.drawn_line       = drawn ? cur.line : '0;
  end

endmodule

### rtl/lcd_scanline_mode_timer.sv
// Scanline and mode timer, top level: state and result registers around lsmt_step.
// Depends on lsmt_pkg, lsmt_if.sv and lsmt_step.
//
//   Channel  Direction  Carries
//   item     in         cycles, enable, compare line, four interrupt selects
//   result   out        mode, line, match, interrupts, drawn line
//
// One item per cycle while the result is not stalled; its result is registered and offered on the next cycle.
// The timing state lives in a single register updated on every item transfer.
// Synchronous reset clears the state to line 0, horizontal blank, empty count.
// A stalled result holds the result register; items are taken while the result
// register is empty or being emptied in the same cycle.

module lcd_scanline_mode_timer (
  input logic          clk,
  input logic          rst,
  lsmt_item_if.sink    item,
  lsmt_result_if.source result
);
  import lsmt_pkg::*;

  lsmt_state_t  state;
  lsmt_state_t  state_next;
  lsmt_result_t res_next;
  lsmt_result_t res;
  logic         out_valid;
  logic         take;

  assign item.ready = !out_valid || result.ready;
  assign take       = item.valid && item.ready;

  lsmt_step u_step (
    .cur                (state),
    .cycles             (item.cycles),
    .ppu_enable         (item.ppu_enable),
    .compare_line       (item.compare_line),
    .compare_int_select (item.compare_int_select),
    .hblank_int_select  (item.hblank_int_select),
    .vblank_int_select  (item.vblank_int_select),
    .oam_int_select     (item.oam_int_select),
    .nxt                (state_next),
    .res                (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{acc: '0, mode: MODE_HBLANK, line: '0, match: 1'b0};
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.mode             = res.mode;
  assign result.line             = res.line;
  assign result.line_match       = res.line_match;
  assign result.stat_interrupt   = res.stat_interrupt;
  assign result.vblank_interrupt = res.vblank_interrupt;
  assign result.line_drawn       = res.line_drawn;
  assign result.drawn_line       = res.drawn_line;

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    state.line <= LINE_W'(LAST_LINE))
    else $error("line counter beyond the last line");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    state.acc <= ACC_MAX - ACC_W'(LINE_CYCLES))
    else $error("cycle accumulator out of range");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.vblank_interrupt |-> res.mode == MODE_VBLANK)
    else $error("vblank interrupt outside vertical blank");

  a_drawn_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.line_drawn |-> res.drawn_line < LINE_W'(VISIBLE_LINES))
    else $error("drawn line is not a visible line");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(res) && $stable(state))
    else $error("result or state changed while the result was stalled");

endmodule
